### src/dpq_pkg.sv
// shared types, codes and default sizes for the deferred-call queue
package dpq_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_PUSH_NORMAL = 2'd0;
  localparam op_t OP_PUSH_HIGH   = 2'd1;
  localparam op_t OP_POP         = 2'd2;

  localparam status_t ST_PUSHED = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_POPPED = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

  localparam int unsigned DEF_NORMAL_DEPTH = 16;
  localparam int unsigned DEF_HIGH_DEPTH   = 4;
  localparam bit          DEF_HIGH_ENABLE  = 1'b1;

endpackage

### src/dpq_if.sv
// request and result channel interfaces of the deferred-call queue
interface dpq_in_if import dpq_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         op;
  logic [31:0] handler_addr;
  logic [31:0] call_param;

  modport source (output valid, output op, output handler_addr, output call_param,
                  input ready);
  modport sink (input valid, input op, input handler_addr, input call_param,
                output ready);
endinterface

interface dpq_out_if import dpq_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] out_handler;
  logic [31:0] out_param;
  logic        from_high;

  modport source (output valid, output status, output out_handler, output out_param,
                  output from_high, input ready);
  modport sink (input valid, input status, input out_handler, input out_param,
                input from_high, output ready);
endinterface

### src/two_priority_deferred_call_queue.sv
// strict-priority queue of deferred-call entries with normal and high fifos
//
// in_word carries one request word: op 0 pushes into the normal fifo, op 1
// into the high-priority fifo, op 2 or 3 pops one entry. every request gives
// exactly one result word on out_word with a status, and for a pop the
// handler address, parameter word and the fifo it came from.
// a request is taken at the clock edge where valid and ready are high. the
// result appears in the next cycle from the output register, and one request
// can be taken every cycle as long as the receiver keeps taking results.
// the rate is set by the single output register: a new request is taken
// when it is empty or being emptied in the same cycle, so when out_word
// stalls, in_word.ready drops until the waiting result is taken.
// each fifo is a memory with one write and one registered read port; the
// read data register doubles as the result register for popped entries.
// synchronous reset on rst_n clears indices, counts and the output valid;
// the stores are not cleared and are only read at slots already pushed.
// with HIGH_ENABLE 0 a high-priority push reports full and pops serve only
// the normal fifo.
module two_priority_deferred_call_queue import dpq_pkg::*; #(
  parameter int unsigned NORMAL_DEPTH = DEF_NORMAL_DEPTH,
  parameter int unsigned HIGH_DEPTH   = DEF_HIGH_DEPTH,
  parameter bit          HIGH_ENABLE  = DEF_HIGH_ENABLE
) (
  input  logic     clk,
  input  logic     rst_n,
  dpq_in_if.sink   in_word,
  dpq_out_if.source out_word
);

  localparam int unsigned N_IDX_W = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int unsigned H_IDX_W = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int unsigned N_CNT_W = $clog2(NORMAL_DEPTH + 1);
  localparam int unsigned H_CNT_W = $clog2(HIGH_DEPTH + 1);

  typedef struct packed {
    logic [31:0] handler;
    logic [31:0] param;
  } entry_t;

  entry_t nrm_mem [NORMAL_DEPTH];
  entry_t hi_mem  [HIGH_DEPTH];

  logic [N_IDX_W-1:0] nrm_wr_r, nrm_wr_nxt, nrm_rd_r, nrm_rd_nxt;
  logic [N_CNT_W-1:0] nrm_cnt_r, nrm_cnt_nxt;
  logic [H_IDX_W-1:0] hi_wr_r, hi_wr_nxt, hi_rd_r, hi_rd_nxt;
  logic [H_CNT_W-1:0] hi_cnt_r, hi_cnt_nxt;

  entry_t  nrm_q_r, hi_q_r;
  logic    out_valid_r, out_valid_nxt;
  status_t status_r, status_nxt;
  logic    popped_r, from_high_r;

  logic   accept;
  logic   push_n, push_h, pop_n, pop_h, is_pop;
  entry_t wr_entry;

  assign accept   = in_word.valid && in_word.ready;
  assign wr_entry = '{handler: in_word.handler_addr, param: in_word.call_param};

  always_comb begin
    push_n = 1'b0;
    push_h = 1'b0;
    is_pop = 1'b0;
    unique case (in_word.op)
      OP_PUSH_NORMAL: push_n = nrm_cnt_r != N_CNT_W'(NORMAL_DEPTH);
      OP_PUSH_HIGH:   push_h = HIGH_ENABLE && (hi_cnt_r != H_CNT_W'(HIGH_DEPTH));
      default:        is_pop = 1'b1;
    endcase
    pop_h = is_pop && HIGH_ENABLE && (hi_cnt_r != '0);
    pop_n = is_pop && !pop_h && (nrm_cnt_r != '0);

    priority if (push_n || push_h) begin
      status_nxt = ST_PUSHED;
    end else if (pop_n || pop_h) begin
      status_nxt = ST_POPPED;
    end else if (is_pop) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_FULL;
    end

    nrm_wr_nxt  = nrm_wr_r;
    nrm_rd_nxt  = nrm_rd_r;
    nrm_cnt_nxt = nrm_cnt_r;
    hi_wr_nxt   = hi_wr_r;
    hi_rd_nxt   = hi_rd_r;
    hi_cnt_nxt  = hi_cnt_r;
    if (accept) begin
      if (push_n) begin
        nrm_wr_nxt  = (nrm_wr_r == N_IDX_W'(NORMAL_DEPTH - 1)) ? '0 : nrm_wr_r + 1'b1;
        nrm_cnt_nxt = nrm_cnt_r + 1'b1;
      end
      if (pop_n) begin
        nrm_rd_nxt  = (nrm_rd_r == N_IDX_W'(NORMAL_DEPTH - 1)) ? '0 : nrm_rd_r + 1'b1;
        nrm_cnt_nxt = nrm_cnt_r - 1'b1;
      end
      if (push_h) begin
        hi_wr_nxt  = (hi_wr_r == H_IDX_W'(HIGH_DEPTH - 1)) ? '0 : hi_wr_r + 1'b1;
        hi_cnt_nxt = hi_cnt_r + 1'b1;
      end
      if (pop_h) begin
        hi_rd_nxt  = (hi_rd_r == H_IDX_W'(HIGH_DEPTH - 1)) ? '0 : hi_rd_r + 1'b1;
        hi_cnt_nxt = hi_cnt_r - 1'b1;
      end
    end

    out_valid_nxt = accept || (out_valid_r && !out_word.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_wr_r    <= '0;
      nrm_rd_r    <= '0;
      nrm_cnt_r   <= '0;
      hi_wr_r     <= '0;
      hi_rd_r     <= '0;
      hi_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      nrm_wr_r    <= nrm_wr_nxt;
      nrm_rd_r    <= nrm_rd_nxt;
      nrm_cnt_r   <= nrm_cnt_nxt;
      hi_wr_r     <= hi_wr_nxt;
      hi_rd_r     <= hi_rd_nxt;
      hi_cnt_r    <= hi_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // fifo memories, read data registered
  always_ff @(posedge clk) begin
    if (accept && push_n) begin
      nrm_mem[nrm_wr_r] <= wr_entry;
    end
    if (accept && pop_n) begin
      nrm_q_r <= nrm_mem[nrm_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_h) begin
      hi_mem[hi_wr_r] <= wr_entry;
    end
    if (accept && pop_h) begin
      hi_q_r <= hi_mem[hi_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      popped_r    <= pop_n || pop_h;
      from_high_r <= pop_h;
    end
  end

  assign in_word.ready        = !out_valid_r || out_word.ready;
  assign out_word.valid       = out_valid_r;
  assign out_word.status      = status_r;
  assign out_word.from_high   = popped_r && from_high_r;
  assign out_word.out_handler = !popped_r ? 32'd0
                              : (from_high_r ? hi_q_r.handler : nrm_q_r.handler);
  assign out_word.out_param   = !popped_r ? 32'd0
                              : (from_high_r ? hi_q_r.param : nrm_q_r.param);

endmodule
